// ===== src/rms_pkg.sv =====
// Shared types and constants for the rate monotonic scheduler.
`timescale 1ns / 1ps

package rms_pkg;

    // Register map, byte addresses are 8 * index
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;
    localparam logic [1:0] REG_TASK_COUNT = 2'd0;
    localparam logic [1:0] REG_EXEC_TIMES = 2'd1;
    localparam logic [1:0] REG_PERIODS    = 2'd2;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
    } status_t;

endpackage

// ===== src/rms_ctrl.sv =====
// Controller state machine: accept a tick, scan the tasks, publish the item.
`timescale 1ns / 1ps

module rms_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  rms_pkg::status_t status,
    output rms_pkg::cmd_t    cmd
);

    rms_pkg::state_t state_reg;
    rms_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rms_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == rms_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    // Sequence the scan and hand results to the output register
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            rms_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rms_pkg::ST_SCAN;
                end
            end
            rms_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = rms_pkg::ST_FINISH;
                end
            end
            rms_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rms_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rms_dp.sv =====
// Datapath: task state, one-task-per-cycle release and selection, result register.
`timescale 1ns / 1ps

module rms_dp #(
    parameter int NUM_TASKS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rms_pkg::cmd_t    cmd,
    output rms_pkg::status_t status,
    input  logic             restart,
    input  logic [3:0]       task_count,
    input  logic [63:0]      exec_times,
    input  logic [63:0]      periods,
    output logic [31:0]      tick_time,
    output logic [3:0]       run_task,
    output logic             idle,
    output logic [7:0]       missed_mask
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    logic [7:0]           work_reg [NUM_TASKS];
    logic [7:0]           cd_reg   [NUM_TASKS];
    logic [31:0]          time_reg;
    logic                 restart_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [NUM_TASKS-1:0] missed_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [7:0]           best_per_reg;
    logic [7:0]           best_work_reg;
    logic [31:0]          out_time_reg;
    logic [3:0]           out_task_reg;
    logic                 out_idle_reg;
    logic [7:0]           out_missed_reg;

    logic [5:0] fsel;
    logic [7:0] per;
    logic [7:0] exe;
    logic [7:0] wl;
    logic [7:0] cd;
    logic       en;
    logic       rel;
    logic [7:0] wl_next;
    logic [7:0] cd_next;
    logic       pick;

    // Evaluate the task under the scan index
    always_comb
    begin
        fsel    = 6'({idx_reg, 3'b000});
        per     = periods[fsel +: 8];
        exe     = exec_times[fsel +: 8];
        wl      = restart_reg ? 8'd0 : work_reg[idx_reg];
        cd      = restart_reg ? 8'd0 : cd_reg[idx_reg];
        en      = (4'(idx_reg) < task_count) && (per != 8'd0);
        rel     = en && (cd == 8'd0);
        wl_next = rel ? exe : wl;
        cd_next = rel ? per : cd;
        if (en && (cd_next != 8'd0))
        begin
            cd_next = cd_next - 8'd1;
        end
        pick    = en && (wl_next != 8'd0) && (!found_reg || (per < best_per_reg));
    end

    assign status.scan_last = (idx_reg == LAST_IDX);

    // Update per-task work and countdowns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                work_reg[i] <= 8'd0;
                cd_reg[i]   <= 8'd0;
            end
        end
        else if (cmd.scan)
        begin
            work_reg[idx_reg] <= wl_next;
            cd_reg[idx_reg]   <= cd_next;
        end
        else if (cmd.finish && found_reg)
        begin
            work_reg[best_idx_reg] <= best_work_reg - 8'd1;
        end
    end

    // Track time and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg    <= 32'd0;
            restart_reg <= 1'b0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            missed_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                restart_reg <= restart;
                idx_reg     <= '0;
                found_reg   <= 1'b0;
                missed_reg  <= '0;
                if (restart)
                begin
                    time_reg <= 32'd0;
                end
            end
            if (cmd.scan)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (rel && (wl != 8'd0))
                begin
                    missed_reg[idx_reg] <= 1'b1;
                end
                if (pick)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                time_reg <= time_reg + 32'd1;
            end
        end
    end

    // Keep the best candidate so far
    always_ff @(posedge clk)
    begin
        if (cmd.scan && pick)
        begin
            best_idx_reg  <= idx_reg;
            best_per_reg  <= per;
            best_work_reg <= wl_next;
        end
    end

    // Capture the result item
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_time_reg   <= time_reg;
            out_task_reg   <= found_reg ? (4'(best_idx_reg) + 4'd1) : 4'd0;
            out_idle_reg   <= !found_reg;
            out_missed_reg <= 8'(missed_reg);
        end
    end

    assign tick_time   = out_time_reg;
    assign run_task    = out_task_reg;
    assign idle        = out_idle_reg;
    assign missed_mask = out_missed_reg;

endmodule

// ===== src/rate_monotonic_scheduler_core.sv =====
// Rate monotonic scheduler top level: config registers, streams, controller and datapath.
// A tick is accepted, the single-task scan loop visits one task entry per cycle, and
// the result is then published; publishing stalls while the output register still
// holds an unaccepted result, and no new tick is accepted during that stall.
// A new tick is accepted while the previous result still waits on the output.
// Reset (rst_n, async, active low) clears registers, time, work and countdowns.
`timescale 1ns / 1ps

module rate_monotonic_scheduler_core #(
    parameter int NUM_TASKS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rms_pkg::ADDR_W-1:0]       paddr,
    input  logic [rms_pkg::DATA_W-1:0]       pwdata,
    output logic [rms_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] restart, [7:1] zero
    input  logic [rms_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] tick_time, [35:32] run_task, [43:36] missed_mask, [47:44] zero
    output logic [rms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] idle
    output logic                             m_axis_tuser
);

    logic [3:0]       task_count_reg;
    logic [63:0]      exec_times_reg;
    logic [63:0]      periods_reg;
    logic             wr_en;
    logic [1:0]       reg_sel;
    rms_pkg::cmd_t    cmd;
    rms_pkg::status_t status;
    logic [31:0]      tick_time;
    logic [3:0]       run_task;
    logic             idle;
    logic [7:0]       missed_mask;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:3];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= 4'd0;
            exec_times_reg <= 64'd0;
            periods_reg    <= 64'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                rms_pkg::REG_TASK_COUNT: task_count_reg <= pwdata[3:0];
                rms_pkg::REG_EXEC_TIMES: exec_times_reg <= pwdata;
                rms_pkg::REG_PERIODS:    periods_reg    <= pwdata;
                default:                 ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (reg_sel)
            rms_pkg::REG_TASK_COUNT: prdata = 64'(task_count_reg);
            rms_pkg::REG_EXEC_TIMES: prdata = exec_times_reg;
            rms_pkg::REG_PERIODS:    prdata = periods_reg;
            default:                 prdata = 64'd0;
        endcase
    end

    rms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rms_dp #(
        .NUM_TASKS (NUM_TASKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .restart     (s_axis_tdata[0]),
        .task_count  (task_count_reg),
        .exec_times  (exec_times_reg),
        .periods     (periods_reg),
        .tick_time   (tick_time),
        .run_task    (run_task),
        .idle        (idle),
        .missed_mask (missed_mask)
    );

    assign m_axis_tdata = {4'd0, missed_mask, run_task, tick_time};
    assign m_axis_tuser = idle;

`ifndef SYNTHESIS
    // A published item is idle exactly when no task number is reported
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((run_task == 4'd0) == idle))
        else $error("idle flag disagrees with run_task");

    // Only one tick is in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted during a scan");

    // Reported task number stays within the configured task range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(run_task) <= 32'(NUM_TASKS)))
        else $error("run_task beyond NUM_TASKS");
`endif

endmodule
